// File: rtl/core/wsht_pkg.sv
// Package for the window stack hit test block: operation and status codes,
// coordinate widths, the queued command type and default sizes. No dependencies.
`default_nettype none

package wsht_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int X_W      = 12;
    localparam int Y_W      = 11;
    localparam int STATUS_W = 2;
    localparam int NUMBER_W = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CLICK = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd3;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic           is_click;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] rx;
        logic [Y_W-1:0] by;
    } cmd_t;

    // Handshake of the command queue, seen from one side
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

`default_nettype wire

// File: rtl/core/wsht_intf.sv
// Channel interfaces of the window stack hit test block: the input item
// channel and the result channel. Depends on wsht_pkg.
`default_nettype none

interface wsht_in_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [wsht_pkg::X_W-1:0]  left_x;
    logic [wsht_pkg::Y_W-1:0]  top_y;
    logic [wsht_pkg::X_W-1:0]  right_x;
    logic [wsht_pkg::Y_W-1:0]  bottom_y;

    modport source (output valid, output operation, output left_x, output top_y,
                    output right_x, output bottom_y, input ready);
    modport sink   (input valid, input operation, input left_x, input top_y,
                    input right_x, input bottom_y, output ready);
endinterface

interface wsht_out_if;
    logic                          valid;
    logic                          ready;
    logic [wsht_pkg::STATUS_W-1:0] status;
    logic [wsht_pkg::NUMBER_W-1:0] window_number;

    modport source (output valid, output status, output window_number, input ready);
    modport sink   (input valid, input status, input window_number, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wsht_front.sv
// Front end: registers incoming items, classifies them into load or click
// commands and pushes them into the command queue. Depends on wsht_pkg, wsht_intf.
`default_nettype none

module wsht_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    wsht_in_if.sink             items,
    output wsht_pkg::hs_t       push_hs_out,
    input  wire logic           push_ready,
    output wsht_pkg::cmd_t      push_data
);

    logic           held_valid_reg;
    logic           held_valid_next;
    wsht_pkg::cmd_t held_cmd_reg;
    wsht_pkg::cmd_t cmd_next;
    logic           take;

    assign items.ready = !held_valid_reg || push_ready;
    assign take        = items.valid && items.ready;

    always_comb
    begin
        cmd_next.x  = items.left_x;
        cmd_next.y  = items.top_y;
        cmd_next.rx = items.right_x;
        cmd_next.by = items.bottom_y;
        unique case (items.operation)
            wsht_pkg::OP_LOAD:  cmd_next.is_click = 1'b0;
            wsht_pkg::OP_CLICK: cmd_next.is_click = 1'b1;
            default:            cmd_next.is_click = 1'b0;
        endcase
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (take)
            held_valid_next = 1'b1;
        else if (push_ready)
            held_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_valid_reg <= 1'b0;
        else
            held_valid_reg <= held_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            held_cmd_reg <= cmd_next;
    end

    assign push_hs_out.valid = held_valid_reg;
    assign push_hs_out.ready = push_ready;
    assign push_data         = held_cmd_reg;

endmodule

`default_nettype wire

// File: rtl/core/wsht_queue.sv
// Short command queue between front and back end, so that each side can
// stall on its own. Depends on wsht_pkg.
`default_nettype none

module wsht_queue #(
    parameter int DEPTH = wsht_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wsht_pkg::hs_t       push_hs,
    output logic                push_ready,
    input  wsht_pkg::cmd_t      push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output wsht_pkg::cmd_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsht_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_hs.valid && push_hs.ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/core/wsht_back.sv
// Back end: holds the window stack in flip-flops, compares a click against
// all entries at once, reorders the stack and drives the result register.
// Depends on wsht_pkg, wsht_intf.
`default_nettype none

module wsht_back #(
    parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wsht_pkg::cmd_t      pop_data,
    wsht_out_if.source          results
);

    localparam int NUM_W = $clog2(MAX_WINDOWS + 1);
    localparam int X_W   = wsht_pkg::X_W;
    localparam int Y_W   = wsht_pkg::Y_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic [X_W-1:0]   lx_reg  [MAX_WINDOWS];
    logic [Y_W-1:0]   ty_reg  [MAX_WINDOWS];
    logic [X_W-1:0]   rx_reg  [MAX_WINDOWS];
    logic [Y_W-1:0]   by_reg  [MAX_WINDOWS];
    logic [NUM_W-1:0] num_reg [MAX_WINDOWS];

    logic [X_W-1:0]   lx_next  [MAX_WINDOWS];
    logic [Y_W-1:0]   ty_next  [MAX_WINDOWS];
    logic [X_W-1:0]   rx_next  [MAX_WINDOWS];
    logic [Y_W-1:0]   by_next  [MAX_WINDOWS];
    logic [NUM_W-1:0] num_next [MAX_WINDOWS];

    logic                   state_reg, state_next;
    logic [NUM_W-1:0]       count_reg, count_next;
    wsht_pkg::cmd_t         cmd_reg;
    logic [MAX_WINDOWS-1:0] match_reg, match_next;
    logic                   do_pop;
    logic                   stack_we;

    logic                          out_valid_reg, out_valid_next;
    logic [wsht_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [wsht_pkg::NUMBER_W-1:0] out_number_reg, out_number_next;

    // Selected window on a hit, gathered through the one-hot first match
    logic [MAX_WINDOWS-1:0] first;
    logic [MAX_WINDOWS-1:0] shift;
    logic                   any_hit;
    logic [X_W-1:0]         hit_lx;
    logic [Y_W-1:0]         hit_ty;
    logic [X_W-1:0]         hit_rx;
    logic [Y_W-1:0]         hit_by;
    logic [NUM_W-1:0]       hit_num;
    logic                   stack_full;
    logic [NUM_W-1:0]       new_num;
    logic [31:0]            report_num;

    // Result slot is free by the time the command reaches the eval cycle
    assign pop_ready = (state_reg == S_IDLE) && (!out_valid_reg || results.ready);
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOWS; k++)
        begin
            match_next[k] = (NUM_W'(k) < count_reg)
                          && (lx_reg[k] <= pop_data.x) && (ty_reg[k] <= pop_data.y)
                          && (rx_reg[k] >= pop_data.x) && (by_reg[k] >= pop_data.y);
        end
    end

    always_comb
    begin
        logic seen;
        seen    = 1'b0;
        hit_lx  = '0;
        hit_ty  = '0;
        hit_rx  = '0;
        hit_by  = '0;
        hit_num = '0;
        for (int k = 0; k < MAX_WINDOWS; k++)
        begin
            shift[k] = seen;
            first[k] = match_reg[k] && !seen;
            seen     = seen || match_reg[k];
            if (first[k])
            begin
                hit_lx  = hit_lx  | lx_reg[k];
                hit_ty  = hit_ty  | ty_reg[k];
                hit_rx  = hit_rx  | rx_reg[k];
                hit_by  = hit_by  | by_reg[k];
                hit_num = hit_num | num_reg[k];
            end
        end
        any_hit = seen;
    end

    assign stack_full = count_reg >= NUM_W'(MAX_WINDOWS);
    assign new_num    = count_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        stack_we        = 1'b0;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        report_num      = '0;
        for (int k = 0; k < MAX_WINDOWS; k++)
        begin
            lx_next[k]  = lx_reg[k];
            ty_next[k]  = ty_reg[k];
            rx_next[k]  = rx_reg[k];
            by_next[k]  = by_reg[k];
            num_next[k] = num_reg[k];
        end

        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (do_pop)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                if (!cmd_reg.is_click)
                begin
                    if (stack_full)
                    begin
                        out_status_next = wsht_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        stack_we        = 1'b1;
                        count_next      = new_num;
                        out_status_next = wsht_pkg::STATUS_LOADED;
                        report_num      = 32'(new_num);
                        lx_next[0]      = cmd_reg.x;
                        ty_next[0]      = cmd_reg.y;
                        rx_next[0]      = cmd_reg.rx;
                        by_next[0]      = cmd_reg.by;
                        num_next[0]     = new_num;
                        for (int k = 1; k < MAX_WINDOWS; k++)
                        begin
                            lx_next[k]  = lx_reg[k-1];
                            ty_next[k]  = ty_reg[k-1];
                            rx_next[k]  = rx_reg[k-1];
                            by_next[k]  = by_reg[k-1];
                            num_next[k] = num_reg[k-1];
                        end
                    end
                end
                else if (any_hit)
                begin
                    stack_we        = 1'b1;
                    out_status_next = wsht_pkg::STATUS_HIT;
                    report_num      = 32'(hit_num);
                    lx_next[0]      = hit_lx;
                    ty_next[0]      = hit_ty;
                    rx_next[0]      = hit_rx;
                    by_next[0]      = hit_by;
                    num_next[0]     = hit_num;
                    // entries above the hit slide down one place
                    for (int k = 1; k < MAX_WINDOWS; k++)
                    begin
                        if (!shift[k])
                        begin
                            lx_next[k]  = lx_reg[k-1];
                            ty_next[k]  = ty_reg[k-1];
                            rx_next[k]  = rx_reg[k-1];
                            by_next[k]  = by_reg[k-1];
                            num_next[k] = num_reg[k-1];
                        end
                    end
                end
                else
                begin
                    out_status_next = wsht_pkg::STATUS_IGNORED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_number_next = (state_reg == S_EVAL) ? report_num[wsht_pkg::NUMBER_W-1:0]
                                                : out_number_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            cmd_reg   <= pop_data;
            match_reg <= match_next;
        end
        out_status_reg <= out_status_next;
        out_number_reg <= out_number_next;
        if (stack_we)
        begin
            for (int k = 0; k < MAX_WINDOWS; k++)
            begin
                lx_reg[k]  <= lx_next[k];
                ty_reg[k]  <= ty_next[k];
                rx_reg[k]  <= rx_next[k];
                by_reg[k]  <= by_next[k];
                num_reg[k] <= num_next[k];
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.status        = out_status_reg;
    assign results.window_number = out_number_reg;

endmodule

`default_nettype wire

// File: rtl/core/window_stack_hit_test.sv
// Top level of the window stack hit test block: front end, command queue
// and back end. Depends on wsht_pkg, wsht_intf, wsht_front, wsht_queue, wsht_back.
//
// Keeps a z-ordered stack of up to MAX_WINDOWS rectangles in flip-flops, top
// entry first. A load item pushes a rectangle on top and numbers it by load
// order (status loaded), or is dropped with status full when the stack is full.
// A click item is compared against every entry in parallel; the topmost
// rectangle containing the point, edges included, moves to the top and its
// number comes back with status hit, otherwise status ignored with number 0.
// Every item gives exactly one result. The back end handles an item in order
// through the registered parallel compare, then the reorder and result write,
// and takes no new item before that write; from input to result an item passes
// through the input register, the queue, the compare register and the result
// register. The stack needs no clearing after reset: only the fill count is reset.
`default_nettype none

module window_stack_hit_test #(
    parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wsht_in_if.sink    items,
    wsht_out_if.source results
);

    wsht_pkg::hs_t  push_hs;
    logic           push_ready;
    wsht_pkg::cmd_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    wsht_pkg::cmd_t pop_data;

    wsht_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .push_hs_out (push_hs),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    wsht_queue #(
        .DEPTH (wsht_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_hs    (push_hs),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wsht_back #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule

`default_nettype wire
